@@ hw/rtl/sdre_pkg.sv @@
`default_nettype none
package sdre_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned TABLE_W    = 2 * CFG_DATA_W;
  localparam int unsigned MAX_DIGITS = VALUE_W;
  localparam int unsigned PTR_W      = $clog2(MAX_DIGITS);
  localparam int unsigned NDIG_W     = PTR_W + 1;
  localparam int unsigned STEP_W     = $clog2(VALUE_W);

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = CFG_IDX_W'(1);

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } sdre_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } sdre_div_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/signed_radix_digit_emitter.sv @@
// Each request first checks the symbol table; if it is invalid the value is dropped with no output.
// Otherwise every digit takes a 32-step restoring division in the shared one-bit divider.
// Characters then leave at one per cycle while the consumer does not stall.
// One request is taken at a time; a new value is taken the cycle after the last character is loaded.
// Reset is asynchronous and active low and clears both symbol registers (table invalid).
`default_nettype none
module signed_radix_digit_emitter import sdre_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VALUE_W-1:0]    value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CHAR_W-1:0]          character_o,
  output logic                       last_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DIG_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int unsigned RAD_W = $clog2(MAX_SYMBOLS + 1);

  sdre_state_e         state_q, state_d;
  logic [CFG_DATA_W-1:0] sym_low_q, sym_high_q;
  logic [VALUE_W-1:0]  value_q;
  logic                sign_pend_q, sign_pend_d;
  logic [NDIG_W-1:0]   nd_q, nd_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [DIG_W-1:0]    digits_q [MAX_DIGITS];
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   char_q, char_d;
  logic                last_q, last_d;

  logic [RAD_W-1:0]    radix;
  logic                tbl_valid;
  logic [CHAR_W-1:0]   symbol;
  logic [VALUE_W-1:0]  mag;
  logic                div_start;
  logic [VALUE_W-1:0]  div_dividend;
  sdre_div_stat_t      div_stat;
  logic [VALUE_W-1:0]  quotient;
  logic [DIG_W-1:0]    remainder;
  logic                more_digits;
  logic                out_free;
  logic                out_load;
  logic                in_accept;

  sdre_table #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .DIG_W       (DIG_W),
    .RAD_W       (RAD_W)
  ) u_table (
    .table_i  ({sym_high_q, sym_low_q}),
    .digit_i  (digits_q[ptr_q]),
    .radix_o  (radix),
    .valid_o  (tbl_valid),
    .symbol_o (symbol)
  );

  sdre_divider #(
    .DIG_W (DIG_W),
    .RAD_W (RAD_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (radix),
    .stat_o      (div_stat),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  assign mag          = value_q[VALUE_W-1] ? (~value_q + VALUE_W'(1)) : value_q;
  assign more_digits  = (quotient != '0) && (nd_q < NDIG_W'(MAX_DIGITS - 1));
  assign div_start    = ((state_q == ST_CHECK) && tbl_valid) ||
                        ((state_q == ST_DIVIDE) && div_stat.done && more_digits);
  assign div_dividend = (state_q == ST_CHECK) ? mag : quotient;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == ST_EMIT) && out_free;

  always_comb begin
    state_d     = state_q;
    sign_pend_d = sign_pend_q;
    nd_d        = nd_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (tbl_valid) begin
          sign_pend_d = value_q[VALUE_W-1];
          nd_d        = '0;
          state_d     = ST_DIVIDE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          nd_d = nd_q + NDIG_W'(1);
          if (!more_digits) begin
            ptr_d   = nd_q[PTR_W-1:0];
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            char_d      = MINUS_CHAR;
            last_d      = 1'b0;
            sign_pend_d = 1'b0;
          end else begin
            char_d = symbol;
            last_d = (ptr_q == '0);
            if (ptr_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              ptr_d = ptr_q - PTR_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sign_pend_q <= 1'b0;
      nd_q        <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      sym_low_q   <= '0;
      sym_high_q  <= '0;
    end else begin
      state_q     <= state_d;
      sign_pend_q <= sign_pend_d;
      nd_q        <= nd_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SYMBOLS_LOW:  sym_low_q  <= cfg_data_i;
          CFG_SYMBOLS_HIGH: sym_high_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    if (in_accept) begin
      value_q <= value_i;
    end
    if ((state_q == ST_DIVIDE) && div_stat.done) begin
      digits_q[nd_q[PTR_W-1:0]] <= remainder;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIVIDE))
    else $error("divider finished outside the divide phase");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !div_stat.busy)
    else $error("new value taken while the divider is busy");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (NDIG_W'(ptr_q) < nd_q))
    else $error("digit pointer beyond the stored digits");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= NDIG_W'(MAX_DIGITS))
    else $error("digit count overflow");

  a_minus_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && sign_pend_q) |-> value_q[VALUE_W-1])
    else $error("minus sign for a non-negative value");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/sdre_table.sv @@
`default_nettype none
module sdre_table import sdre_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 16,
  parameter int unsigned DIG_W       = 4,
  parameter int unsigned RAD_W       = 5
) (
  input  wire logic [TABLE_W-1:0] table_i,
  input  wire logic [DIG_W-1:0]   digit_i,
  output logic [RAD_W-1:0]        radix_o,
  output logic                    valid_o,
  output logic [CHAR_W-1:0]       symbol_o
);

  localparam int unsigned ENTRIES = 2 ** DIG_W;

  logic [CHAR_W-1:0] sym [ENTRIES];
  logic              dup;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      sym[i] = (i < MAX_SYMBOLS) ? table_i[i*CHAR_W +: CHAR_W] : '0;
    end
  end

  always_comb begin
    radix_o = RAD_W'(MAX_SYMBOLS);
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (sym[i] == '0) begin
        radix_o = RAD_W'(i);
      end
    end
  end

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if ((j < int'(radix_o)) && (sym[i] == sym[j])) begin
          dup = 1'b1;
        end
      end
    end
  end

  assign valid_o  = (radix_o >= RAD_W'(2)) && !dup;
  assign symbol_o = sym[digit_i];

endmodule
`default_nettype wire

@@ hw/rtl/sdre_divider.sv @@
`default_nettype none
module sdre_divider import sdre_pkg::*; #(
  parameter int unsigned DIG_W = 4,
  parameter int unsigned RAD_W = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [VALUE_W-1:0] dividend_i,
  input  wire logic [RAD_W-1:0]   divisor_i,
  output sdre_div_stat_t          stat_o,
  output logic [VALUE_W-1:0]      quotient_o,
  output logic [DIG_W-1:0]        remainder_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [VALUE_W-1:0]  quo_q, quo_d;
  logic [DIG_W-1:0]    rem_q, rem_d;
  logic [DIG_W:0]      trial;
  logic [DIG_W:0]      div_ext;
  logic                fits;

  // One restoring step per cycle while busy: shift in the next dividend bit and subtract if it fits.
  assign trial   = {rem_q, quo_q[VALUE_W-1]};
  assign div_ext = (DIG_W + 1)'(divisor_i);
  assign fits    = trial >= div_ext;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(VALUE_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = fits ? DIG_W'(trial - div_ext) : DIG_W'(trial);
      quo_d  = {quo_q[VALUE_W-2:0], fits};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule
`default_nettype wire
